### rtl/sliding_window_max_sum_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window max sum block
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_SUM_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MAX_SUM_TOP_ASSERT_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define SWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset
`define SWMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SWMS_ASSERT(lbl, prop, msg)
`define SWMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/swms_pkg.sv
// ---------------------------------------------------------------------------
// swms_pkg
// Types and constants shared by the sliding window max sum block.
// ---------------------------------------------------------------------------
package swms_pkg;

  // Ring depth and field widths
  localparam int unsigned MaxWindow  = 64;
  localparam int unsigned RingAw     = $clog2(MaxWindow);
  localparam int unsigned DayBits    = 16;
  localparam int unsigned CountW     = 20;
  localparam int unsigned DaySumW    = 32;
  localparam int unsigned WinSumW    = 38;
  localparam int unsigned WinCfgW    = 7;
  localparam logic [WinCfgW-1:0] WinReset = WinCfgW'(7);

  // Input request
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              day_end;
  } swms_in_t;

  // Result
  typedef struct packed {
    logic [DayBits-1:0] window_start;
    logic [DayBits-1:0] window_end;
    logic [WinSumW-1:0] window_total;
    logic [DayBits-1:0] worst_day;
    logic [DaySumW-1:0] worst_day_total;
  } swms_out_t;

  // Clamp the configured window to 1..MaxWindow
  function automatic logic [WinCfgW-1:0] clamp_window(input logic [WinCfgW-1:0] wd);
    logic [WinCfgW-1:0] w;
    w = wd;
    if (wd == '0) begin
      w = WinCfgW'(1);
    end else if (wd > WinCfgW'(MaxWindow)) begin
      w = WinCfgW'(MaxWindow);
    end
    return w;
  endfunction

endpackage

### rtl/sliding_window_max_sum_top.sv
// ---------------------------------------------------------------------------
// sliding_window_max_sum_top
// Busiest run of days over a stream of per-entry counts.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one count per
//   request; day_end marks the last request of a day. An empty day is one
//   zero count with day_end set. Every day_end request produces one result
//   on the output channel (out_valid_o / out_stall_i / out_data_o); other
//   requests produce none.
//   Latency: result is valid the cycle after the closing request is taken.
//   Throughput: one request per cycle while in_stall_o is low. The old day
//   total leaving the window comes from a ring memory read issued ahead,
//   with a write-to-read bypass, so a day end never holds up the input.
//   cfg_we_i/cfg_wdata_i write the window length (0 acts as 1, above 64 acts
//   as 64); the new length applies from the next day end.
//   Reset clears all counters and sums and sets the window to 7 days; the
//   ring memory needs no clearing since unwritten slots are never read.
//   While the receiver stalls a pending result, in_stall_o is raised and the
//   result is held unchanged.
// ---------------------------------------------------------------------------
module sliding_window_max_sum_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swms_pkg::WinCfgW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  swms_pkg::swms_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output swms_pkg::swms_out_t                 out_data_o
);

  localparam int unsigned DB = swms_pkg::DayBits;
  localparam int unsigned DS = swms_pkg::DaySumW;
  localparam int unsigned WS = swms_pkg::WinSumW;
  localparam int unsigned CW = swms_pkg::WinCfgW;
  localparam int unsigned AW = swms_pkg::RingAw;
  localparam logic [DB-1:0] DayMax = '1;

  // State
  logic [CW-1:0]       window_q, window_d;
  logic [DS-1:0]       day_sum_q, day_sum_d;
  logic [AW-1:0]       ring_pos_q, ring_pos_d;
  logic [DB-1:0]       days_q, days_d;
  logic [WS-1:0]       running_q, running_d;
  logic [DB-1:0]       best_start_q, best_start_d;
  logic [DB-1:0]       best_end_q, best_end_d;
  logic [WS-1:0]       best_total_q, best_total_d;
  logic [DB-1:0]       peak_day_q, peak_day_d;
  logic [DS-1:0]       peak_total_q, peak_total_d;
  logic                out_valid_q, out_valid_d;
  swms_pkg::swms_out_t out_q, out_d;

  // Ring memory and prefetch path
  logic [DS-1:0] ring_mem [swms_pkg::MaxWindow];
  logic [DS-1:0] mem_rd_q;
  logic [DS-1:0] byp_data_q;
  logic          byp_q;
  logic [AW-1:0] rd_addr;
  logic          ring_we;
  logic          byp_hit;
  logic [DS-1:0] old_day;

  // Datapath temporaries
  logic          in_acc;
  logic          day_close;
  logic [DS:0]   sum_ext;
  logic [DS-1:0] day_total;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] w_next;
  logic [DB-1:0] w_ext;
  logic [DB-1:0] n_day;
  logic          filling;
  logic [WS-1:0] slide_sum;
  logic [DB-1:0] worst_day;

  // Handshake
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign day_close   = in_acc & in_data_i.day_end;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Saturating day accumulate
  assign sum_ext   = {1'b0, day_sum_q} + (DS+1)'(in_data_i.count);
  assign day_total = sum_ext[DS] ? '1 : sum_ext[DS-1:0];

  // Window length now and after a pending config write
  assign window_d = cfg_we_i ? cfg_wdata_i : window_q;
  assign w_eff    = swms_pkg::clamp_window(window_q);
  assign w_next   = swms_pkg::clamp_window(window_d);
  assign w_ext    = DB'(w_eff);

  // Day counter, saturating
  assign n_day   = (days_q == DayMax) ? days_q : days_q + DB'(1);
  assign filling = (n_day <= w_ext);

  // Oldest day in the window, prefetched last cycle
  assign old_day   = byp_q ? byp_data_q : mem_rd_q;
  assign slide_sum = running_q - WS'(old_day) + WS'(day_total);

  // Next state
  always_comb begin
    day_sum_d    = day_sum_q;
    ring_pos_d   = ring_pos_q;
    days_d       = days_q;
    running_d    = running_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    best_total_d = best_total_q;
    peak_day_d   = peak_day_q;
    peak_total_d = peak_total_q;
    if (in_acc) begin
      day_sum_d = day_total;
      if (in_data_i.day_end) begin
        day_sum_d  = '0;
        ring_pos_d = ring_pos_q + AW'(1);
        days_d     = n_day;
        if (filling) begin
          running_d    = running_q + WS'(day_total);
          best_start_d = DB'(1);
          best_end_d   = n_day;
          best_total_d = running_q + WS'(day_total);
        end else begin
          running_d = slide_sum;
          if (slide_sum > best_total_q) begin
            best_start_d = n_day - w_ext + DB'(1);
            best_end_d   = n_day;
            best_total_d = slide_sum;
          end
        end
        if (day_total > peak_total_q) begin
          peak_total_d = day_total;
          peak_day_d   = n_day;
        end
      end
    end
  end

  // Result register contents
  assign worst_day = (peak_day_d == '0) ? DB'(1) : peak_day_d;

  always_comb begin
    out_d                 = out_q;
    out_d.window_start    = best_start_d;
    out_d.window_end      = best_end_d;
    out_d.window_total    = best_total_d;
    out_d.worst_day       = worst_day;
    out_d.worst_day_total = peak_total_d;
    if (!day_close) begin
      out_d = out_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (day_close) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Ring read address for the next day end
  assign ring_we = day_close;
  assign rd_addr = ring_pos_d - w_next[AW-1:0];
  assign byp_hit = ring_we & (ring_pos_q == rd_addr);

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= swms_pkg::WinReset;
      day_sum_q    <= '0;
      ring_pos_q   <= '0;
      days_q       <= '0;
      running_q    <= '0;
      best_start_q <= DB'(1);
      best_end_q   <= DB'(1);
      best_total_q <= '0;
      peak_day_q   <= '0;
      peak_total_q <= '0;
      out_valid_q  <= 1'b0;
      byp_q        <= 1'b0;
    end else begin
      window_q     <= window_d;
      day_sum_q    <= day_sum_d;
      ring_pos_q   <= ring_pos_d;
      days_q       <= days_d;
      running_q    <= running_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      best_total_q <= best_total_d;
      peak_day_q   <= peak_day_d;
      peak_total_q <= peak_total_d;
      out_valid_q  <= out_valid_d;
      byp_q        <= byp_hit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    byp_data_q <= day_total;
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_pos_q] <= day_total;
    end
    mem_rd_q <= ring_mem[rd_addr];
  end

  // Assertions
`include "sliding_window_max_sum_top_assert.svh"

  `SWMS_ASSERT(a_day_end_gives_result, day_close |=> out_valid_o, "day end without result")
  `SWMS_ASSERT(a_ring_moves_on_day_end, (in_acc && !in_data_i.day_end) |=> $stable(ring_pos_q), "ring moved mid-day")
  `SWMS_ASSERT(a_window_order, out_valid_o |-> (out_data_o.window_end >= out_data_o.window_start), "window end before start")
  `SWMS_ASSERT_ALWAYS(a_stall_only_when_pending, in_stall_o |-> out_valid_o, "stall without pending result")

endmodule

### dv/sliding_window_max_sum_top_test.sv
// ---------------------------------------------------------------------------
// sliding_window_max_sum_top_test
// Drives count requests into the busiest-window block and checks every day
// report against a predictor kept in step with each accepted request. A short
// table of hand-picked requests comes first, then randomized days under
// several window lengths and a resize that wraps the running sum. Both
// channels idle at random; one long output hold backs the block up into its
// input.
// ---------------------------------------------------------------------------
module sliding_window_max_sum_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned IdleGap    = 4;     // cycles after the last report
  localparam int unsigned HoldAfter  = 40;    // reports seen before the long hold
  localparam int unsigned HoldCycles = 300;
  localparam logic [swms_pkg::CountW-1:0] CntMax = '1;

  typedef struct packed {
    swms_pkg::swms_in_t  req;
    logic                typed;   // want is filled in by hand
    swms_pkg::swms_out_t want;
  } probe_t;

  localparam int NumProbes = 19;
  localparam probe_t Probes [NumProbes] = '{
    // empty first day: all zero, worst day reads as day 1
    '{'{20'h0, 1'b1}, 1'b1, '{16'd1, 16'd1, 38'd0, 16'd1, 32'd0}},
    '{'{CntMax, 1'b0}, 1'b0, '0},
    '{'{CntMax, 1'b1}, 1'b1, '{16'd1, 16'd2, 38'd2097150, 16'd2, 32'd2097150}},
    '{'{20'h0, 1'b1}, 1'b1, '{16'd1, 16'd3, 38'd2097150, 16'd2, 32'd2097150}},
    '{'{CntMax, 1'b0}, 1'b0, '0},
    // ties day 2: worst day stays on the earlier one
    '{'{CntMax, 1'b1}, 1'b1, '{16'd1, 16'd4, 38'd4194300, 16'd2, 32'd2097150}},
    '{'{20'd1, 1'b0}, 1'b0, '0},
    '{'{20'd2, 1'b0}, 1'b0, '0},
    '{'{20'd4, 1'b1}, 1'b0, '0},
    '{'{20'h0, 1'b1}, 1'b0, '0},
    '{'{20'h0, 1'b1}, 1'b0, '0},     // day 7 fills the window
    '{'{20'h0, 1'b1}, 1'b0, '0},     // first slide, equal sum keeps best
    '{'{20'h0, 1'b1}, 1'b0, '0},
    '{'{CntMax, 1'b0}, 1'b0, '0},
    '{'{CntMax, 1'b0}, 1'b0, '0},
    '{'{CntMax, 1'b1}, 1'b0, '0},    // new best window and new worst day
    '{'{CntMax, 1'b1}, 1'b0, '0},
    '{'{20'h0, 1'b0}, 1'b0, '0},
    '{'{20'h0, 1'b1}, 1'b0, '0}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // block ports
  logic                          cfg_we    = 1'b0;
  logic [swms_pkg::WinCfgW-1:0]  cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  swms_pkg::swms_in_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  swms_pkg::swms_out_t           out_data;

  sliding_window_max_sum_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // predictor state
  logic [swms_pkg::WinCfgW-1:0] win_len = swms_pkg::WinReset;
  logic [swms_pkg::DaySumW-1:0] open_day_total = '0;
  logic [swms_pkg::DaySumW-1:0] day_totals [swms_pkg::MaxWindow];
  logic [swms_pkg::RingAw-1:0]  ring_wr = '0;
  logic [swms_pkg::DayBits-1:0] day_count = '0;
  logic [swms_pkg::WinSumW-1:0] win_sum = '0;
  logic [swms_pkg::DayBits-1:0] best_first = 16'd1;
  logic [swms_pkg::DayBits-1:0] best_last = 16'd1;
  logic [swms_pkg::WinSumW-1:0] best_sum = '0;
  logic [swms_pkg::DayBits-1:0] peak_idx = '0;
  logic [swms_pkg::DaySumW-1:0] peak_sum = '0;

  // scoreboard
  swms_pkg::swms_out_t day_reports_q [$];
  int unsigned mismatches   = 0;
  int unsigned reports_seen = 0;
  int unsigned reqs_taken   = 0;
  logic        quiet        = 1'b0;   // no idling on either side
  logic        hold_done    = 1'b0;

  // Folds one request into the day; returns 1 with the report on a day end
  function automatic bit tally_entry(input swms_pkg::swms_in_t e,
                                     output swms_pkg::swms_out_t r);
    logic [swms_pkg::DaySumW:0]   s;
    logic [swms_pkg::DaySumW-1:0] t;
    int unsigned                  w;
    logic [swms_pkg::RingAw-1:0]  old_slot;
    r = '0;
    s = {1'b0, open_day_total} + (swms_pkg::DaySumW+1)'(e.count);
    open_day_total = s[swms_pkg::DaySumW] ? '1 : s[swms_pkg::DaySumW-1:0];
    if (!e.day_end) return 1'b0;
    t = open_day_total;
    open_day_total = '0;
    w = (win_len == '0) ? 1 :
        (win_len > swms_pkg::MaxWindow) ? swms_pkg::MaxWindow : int'(win_len);
    if (day_count != '1) day_count = day_count + 1'b1;
    if (day_count <= w) begin
      // window still filling
      win_sum    = win_sum + swms_pkg::WinSumW'(t);
      best_first = 16'd1;
      best_last  = day_count;
      best_sum   = win_sum;
    end else begin
      old_slot = ring_wr - swms_pkg::RingAw'(w);
      win_sum  = win_sum - swms_pkg::WinSumW'(day_totals[old_slot]) + swms_pkg::WinSumW'(t);
      if (win_sum > best_sum) begin
        best_first = day_count - swms_pkg::DayBits'(w) + 1'b1;
        best_last  = day_count;
        best_sum   = win_sum;
      end
    end
    day_totals[ring_wr] = t;
    ring_wr = ring_wr + 1'b1;
    if (t > peak_sum) begin
      peak_sum = t;
      peak_idx = day_count;
    end
    r.window_start    = best_first;
    r.window_end      = best_last;
    r.window_total    = best_sum;
    r.worst_day       = (peak_idx == '0) ? 16'd1 : peak_idx;
    r.worst_day_total = peak_sum;
    return 1'b1;
  endfunction

  function automatic swms_pkg::swms_in_t mk_req(input logic [swms_pkg::CountW-1:0] c,
                                                input logic last);
    swms_pkg::swms_in_t q;
    q.count   = c;
    q.day_end = last;
    return q;
  endfunction

  function automatic logic [swms_pkg::CountW-1:0] rand_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CntMax;
      2, 3:    return swms_pkg::CountW'($urandom_range(15));
      default: return swms_pkg::CountW'($urandom);
    endcase
  endfunction

  // Offer one request until taken, then predict its report
  task automatic offer(input swms_pkg::swms_in_t req, input bit use_typed,
                       input swms_pkg::swms_out_t typed_res);
    swms_pkg::swms_out_t r;
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    reqs_taken++;
    if (tally_entry(req, r)) day_reports_q = {day_reports_q, (use_typed ? typed_res : r)};
  endtask

  // Stop offering and let every pending report come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (day_reports_q.size() != 0);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [swms_pkg::WinCfgW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    win_len  = v;
  endtask

  // Random days of one to four entries, with some empty days
  task automatic run_days(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        offer(mk_req('0, 1'b1), 1'b0, '0);
        sent++;
      end else begin
        k = $urandom_range(4, 1);
        for (int unsigned j = 1; j <= k; j++) offer(mk_req(rand_count(), j == k), 1'b0, '0);
        sent += k;
      end
    end
  endtask

  // Output side: random stalls, one long hold once enough reports are out
  initial begin : rx_side
    int unsigned held;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && reports_seen >= HoldAfter) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 22);
      end
    end
  end

  task automatic flag_bad(input string why, input swms_pkg::swms_out_t want,
                          input swms_pkg::swms_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] day report %s: want %0d..%0d sum %0d worst %0d/%0d", $realtime, why,
               want.window_start, want.window_end, want.window_total,
               want.worst_day, want.worst_day_total);
      $display("    got %0d..%0d sum %0d worst %0d/%0d", got.window_start, got.window_end,
               got.window_total, got.worst_day, got.worst_day_total);
    end
  endtask

  // Report checker
  always @(posedge clk_i) begin
    swms_pkg::swms_out_t want;
    string               diff;
    if (rst_ni && out_valid && !out_stall) begin
      reports_seen++;
      if (day_reports_q.size() == 0) begin
        flag_bad("with nothing pending", '0, out_data);
      end else begin
        want = day_reports_q.pop_front();
        diff = "";
        if (out_data.window_start !== want.window_start) diff = {diff, " window_start"};
        if (out_data.window_end !== want.window_end) diff = {diff, " window_end"};
        if (out_data.window_total !== want.window_total) diff = {diff, " window_total"};
        if (out_data.worst_day !== want.worst_day) diff = {diff, " worst_day"};
        if (out_data.worst_day_total !== want.worst_day_total) diff = {diff, " worst_day_total"};
        if (diff != "") flag_bad({"wrong", diff}, want, out_data);
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d reports pending", cycle_cnt, day_reports_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin : stim
    logic [swms_pkg::WinCfgW-1:0] mid_len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-picked days under the reset window of 7
    for (int i = 0; i < NumProbes; i++) offer(Probes[i].req, Probes[i].typed, Probes[i].want);

    set_window(7'd0);     // acts as 1
    run_days(120);
    set_window(7'd1);
    run_days(120);
    set_window(7'd64);
    quiet = 1'b1;
    run_days(200);
    quiet = 1'b0;
    set_window(7'd127);   // acts as 64
    run_days(120);
    set_window(7'd65);
    run_days(80);
    mid_len = swms_pkg::WinCfgW'($urandom_range(63, 2));
    set_window(mid_len);
    run_days(150);

    // short windows
    set_window(7'd3);
    run_days(30);
    set_window(7'd5);
    run_days(30);

    // resize without rebuilding the sum: large days age out of a window of 1,
    // then growing to 64 subtracts one of them and wraps the running sum
    set_window(7'd1);
    for (int i = 0; i < 70; i++)
      offer(mk_req((i < 64) ? swms_pkg::CountW'($urandom_range(CntMax, 20'h80000)) : '0,
                   1'b1), 1'b0, '0);
    set_window(7'd64);
    for (int i = 0; i < 10; i++) offer(mk_req(rand_count(), 1'b1), 1'b0, '0);

    drain();
    $display("checked %0d day reports from %0d requests; window lengths 0, 1, 3, 5, 7, %0d,",
             reports_seen, reqs_taken, mid_len);
    $display("64, 65, 127, running sum wrap after a resize, %0d-cycle output hold",
             HoldCycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
